### hdl/yaz0_pkg.sv
// Shared types and constants of the Yaz0 stream decompressor.
`default_nettype none
package yaz0_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int OUT_LANES = 8;
  localparam int LANE_W = $clog2(OUT_LANES);
  localparam int GROUP_SIZE = 8;

  localparam logic [8:0] LEN_SHORT_BIAS = 9'd2;
  localparam logic [8:0] LEN_LONG_BIAS = 9'd18;
  localparam logic [12:0] DIST_BIAS = 13'd1;

  localparam logic [0:0] REG_OUTPUT_LIMIT = 1'b0;

  typedef struct packed {
    logic       in_end;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic        bad_reference;
    logic        stream_done;
    logic        run_last;
    logic [3:0]  out_count;
    logic [63:0] out_bytes;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/yaz0_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module yaz0_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/yaz0_stream_decompressor.sv
// Top level of the Yaz0 stream decompressor: sequencer, history RAM and result register.
//
// Compressed bytes enter one per transfer while the block is idle; a group byte, a literal
// or the first byte of a back-reference passes through the decode and finish states before
// the block is ready again. The byte that completes a back-reference adds the distance and
// length checks, then a read and a write state for each of its 3 to 273 copied bytes and a
// push state per full eight-byte result: each copied byte needs a read and then a write of
// the 4096-byte history RAM, whose read data is registered, and the two range checks share
// one comparator. A stalled result register holds the push or finish state. Results
// wait in an output register, so a new byte can be taken while the last result is stalled.
// The history needs no clearing after reset; output_limit resets to zero.
`default_nettype none
module yaz0_stream_decompressor (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire yaz0_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output yaz0_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_CHK_DIST = 3'd2;
  localparam logic [2:0] S_CHK_LEN  = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_WRITE    = 3'd5;
  localparam logic [2:0] S_PUSH     = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [2:0]  state;
  logic [31:0] output_limit;
  logic [31:0] bytes_written;
  logic [7:0]  group_bits;
  logic [3:0]  group_bits_left;
  logic [1:0]  token_phase;
  logic [7:0]  ref_first;
  logic [7:0]  ref_second;
  logic        halted;

  logic [7:0]  byte_reg;
  logic        end_reg;
  logic        was_halted;
  logic        any_result;
  logic        push_last;
  logic [12:0] ref_dist;
  logic [8:0]  copy_len;
  logic [8:0]  copy_left;
  logic [yaz0_pkg::OUT_LANES-1:0][7:0] acc;
  logic [3:0]  lane_cnt;

  logic [32:0] cmp_a;
  logic [32:0] cmp_b;
  logic        cmp_gt;

  logic                        ram_we;
  logic [yaz0_pkg::WIN_AW-1:0] ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [yaz0_pkg::WIN_AW-1:0] ram_raddr;
  logic [7:0]                  ram_rdata;

  logic                 out_free;
  logic                 out_load;
  yaz0_pkg::out_item_t  out_load_data;
  logic                 need_push;
  logic                 take_group;
  logic                 ref_complete;
  logic                 cfg_write;
  logic [yaz0_pkg::LANE_W-1:0] lane_idx;

  assign in_stall = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == yaz0_pkg::REG_OUTPUT_LIMIT);
  assign prdata = (paddr[2] == yaz0_pkg::REG_OUTPUT_LIMIT) ? output_limit : 32'd0;
  assign lane_idx = lane_cnt[yaz0_pkg::LANE_W-1:0];
  assign out_free = !out_valid || !out_stall;
  assign ref_complete = (token_phase != PH_START) &&
                        !(token_phase == PH_SECOND && ref_first[7:4] == 4'd0);

  always_comb begin
    case (state)
      S_DECODE: begin
        cmp_a = {1'b0, output_limit};
        cmp_b = {1'b0, bytes_written};
      end
      S_CHK_DIST: begin
        cmp_a = {20'd0, ref_dist};
        cmp_b = {1'b0, bytes_written};
      end
      S_CHK_LEN: begin
        cmp_a = {1'b0, bytes_written} + {24'd0, copy_len};
        cmp_b = {1'b0, output_limit};
      end
      default: begin
        cmp_a = 33'd0;
        cmp_b = 33'd0;
      end
    endcase
    cmp_gt = cmp_a > cmp_b;
  end

  assign take_group = (group_bits_left == 4'd0) || !cmp_gt;
  assign need_push = (lane_cnt != 4'd0) ||
                     (!any_result && (end_reg || (halted && !was_halted)));

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = ram_rdata;
    ram_waddr = bytes_written[yaz0_pkg::WIN_AW-1:0];
    ram_raddr = bytes_written[yaz0_pkg::WIN_AW-1:0] - ref_dist[yaz0_pkg::WIN_AW-1:0];
    if (state == S_DECODE && !halted && token_phase == PH_START && !take_group &&
        group_bits[7]) begin
      ram_we = 1'b1;
      ram_wdata = byte_reg;
    end else if (state == S_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    out_load = 1'b0;
    out_load_data.out_bytes = acc;
    out_load_data.out_count = lane_cnt;
    out_load_data.run_last = 1'b1;
    out_load_data.stream_done = end_reg;
    out_load_data.bad_reference = halted;
    if (state == S_PUSH && out_free) begin
      out_load = 1'b1;
      out_load_data.run_last = push_last;
      out_load_data.stream_done = push_last && end_reg;
    end else if (state == S_FINISH && need_push && out_free) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  yaz0_ram #(
    .WIDTH(8),
    .DEPTH(yaz0_pkg::WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      output_limit <= 32'd0;
      bytes_written <= 32'd0;
      group_bits <= 8'd0;
      group_bits_left <= 4'd0;
      token_phase <= PH_START;
      ref_first <= 8'd0;
      ref_second <= 8'd0;
      halted <= 1'b0;
      lane_cnt <= 4'd0;
      any_result <= 1'b0;
      copy_left <= 9'd0;
    end else begin
      if (cfg_write) begin
        output_limit <= pwdata;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_reg <= in_data.in_byte;
            end_reg <= in_data.in_end;
            was_halted <= halted;
            acc <= '0;
            lane_cnt <= 4'd0;
            any_result <= 1'b0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!halted && ref_complete) begin
            state <= S_CHK_DIST;
          end else begin
            state <= S_FINISH;
          end
          if (!halted) begin
            case (token_phase)
              PH_START: begin
                if (take_group) begin
                  group_bits <= byte_reg;
                  group_bits_left <= 4'(yaz0_pkg::GROUP_SIZE);
                end else if (group_bits[7]) begin
                  acc[lane_idx] <= byte_reg;
                  lane_cnt <= lane_cnt + 4'd1;
                  bytes_written <= bytes_written + 32'd1;
                  group_bits <= {group_bits[6:0], 1'b0};
                  group_bits_left <= group_bits_left - 4'd1;
                end else begin
                  ref_first <= byte_reg;
                  token_phase <= PH_SECOND;
                end
              end
              PH_SECOND: begin
                if (ref_first[7:4] == 4'd0) begin
                  ref_second <= byte_reg;
                  token_phase <= PH_THIRD;
                end else begin
                  ref_dist <= {1'b0, ref_first[3:0], byte_reg} + yaz0_pkg::DIST_BIAS;
                  copy_len <= {5'd0, ref_first[7:4]} + yaz0_pkg::LEN_SHORT_BIAS;
                end
              end
              default: begin
                ref_dist <= {1'b0, ref_first[3:0], ref_second} + yaz0_pkg::DIST_BIAS;
                copy_len <= {1'b0, byte_reg} + yaz0_pkg::LEN_LONG_BIAS;
              end
            endcase
            if (ref_complete) begin
              group_bits <= {group_bits[6:0], 1'b0};
              if (group_bits_left != 4'd0) begin
                group_bits_left <= group_bits_left - 4'd1;
              end
              token_phase <= PH_START;
            end
          end
        end
        S_CHK_DIST: begin
          if (cmp_gt) begin
            halted <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_CHK_LEN;
          end
        end
        S_CHK_LEN: begin
          if (cmp_gt) begin
            halted <= 1'b1;
            state <= S_FINISH;
          end else begin
            copy_left <= copy_len;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          acc[lane_idx] <= ram_rdata;
          lane_cnt <= lane_cnt + 4'd1;
          bytes_written <= bytes_written + 32'd1;
          copy_left <= copy_left - 9'd1;
          if (lane_cnt == 4'(yaz0_pkg::OUT_LANES - 1)) begin
            push_last <= (copy_left == 9'd1);
            state <= S_PUSH;
          end else if (copy_left == 9'd1) begin
            state <= S_FINISH;
          end else begin
            state <= S_READ;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            acc <= '0;
            lane_cnt <= 4'd0;
            any_result <= 1'b1;
            state <= push_last ? S_FINISH : S_READ;
          end
        end
        default: begin
          if (!need_push || out_free) begin
            if (end_reg) begin
              bytes_written <= 32'd0;
              group_bits <= 8'd0;
              group_bits_left <= 4'd0;
              token_phase <= PH_START;
              ref_first <= 8'd0;
              ref_second <= 8'd0;
              halted <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_accept_starts_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DECODE))
    else $error("Transfer in did not start a decode.");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stream_done) |-> out_data.run_last)
    else $error("Stream end flagged on a result that is not the last of its byte.");

  a_halt_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_reference) |-> (out_data.out_count == 4'd0))
    else $error("Data delivered after a bad back-reference.");

  a_copy_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (copy_left != 9'd0))
    else $error("History read issued with no bytes left to copy.");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (lane_cnt == 4'(yaz0_pkg::OUT_LANES)))
    else $error("Mid-copy result pushed with a partly filled lane register.");

endmodule
`default_nettype wire
